[sv/lps_pkg.sv]
package lps_pkg;

    localparam int MAX_RES = 32;

    localparam logic [2:0] FN_START_SYS = 3'd0;
    localparam logic [2:0] FN_START_USR = 3'd1;
    localparam logic [2:0] FN_STOP      = 3'd2;
    localparam logic [2:0] FN_OUT_Q     = 3'd3;
    localparam logic [2:0] FN_TICKET    = 3'd4;
    localparam logic [2:0] FN_BALANCE   = 3'd5;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNUSED = 3'd1;
    localparam logic [2:0] ST_BUSY   = 3'd2;
    localparam logic [2:0] ST_LEVEL  = 3'd3;
    localparam logic [2:0] ST_PARENT = 3'd4;

    localparam logic [2:0] CFG_HOLD   = 3'd0;
    localparam logic [2:0] CFG_NQ     = 3'd1;
    localparam logic [2:0] CFG_UQ     = 3'd2;
    localparam logic [2:0] CFG_START  = 3'd3;
    localparam logic [2:0] CFG_MAXTK  = 3'd4;
    localparam logic [2:0] CFG_MINTK  = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_START, S_PAR_RD, S_USER, S_FINOK, S_STOP,
        S_OQ_RD, S_OQ_ACT, S_OQ_RD2, S_OQ_EMIT, S_TK_RD, S_TK_ACT,
        S_W_RD, S_W_ACT, S_DIVCHK, S_DIV
    } t_state;

    typedef enum logic [1:0] {W_BAL, W_BONUS, W_SUM, W_FIND} t_walk;

    typedef enum logic [2:0] {PTR_HOLD, PTR_SLOT, PTR_PARENT, PTR_ZERO, PTR_INC} t_ptr_sel;
    typedef enum logic [2:0] {LV_MAXLEV, LV_HOLD, LV_WIN, LV_INC, LV_DEC} t_lv_sel;
    typedef enum logic [1:0] {TK_START, TK_DEC, TK_INC, TK_DELTA} t_tk_sel;
    typedef enum logic [1:0] {SL_QUANTUM, SL_RD, SL_UQ} t_sl_sel;
    typedef enum logic [2:0] {EM_SYS, EM_USER, EM_RD, EM_BAL, EM_WIN} t_em_sel;

    typedef struct packed {
        logic       load;
        t_ptr_sel   ptr_sel;
        logic       wr_level;
        t_lv_sel    lv_sel;
        logic       wr_maxlev;
        logic       wr_tickets;
        t_tk_sel    tk_sel;
        logic       wr_slice;
        t_sl_sel    sl_sel;
        logic       set_use;
        logic       clr_use;
        logic       set_user;
        logic       clr_user;
        logic       sum_clr;
        logic       sum_add;
        logic       div_start;
        logic       left_load;
        logic       left_sub;
        logic       emit;
        t_em_sel    em_sel;
        logic       finish;
        logic [2:0] status;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       slot_ok;
        logic       slot_used;
        logic       parent_ok;
        logic       lev_bad;
        logic       ent_user;
        logic       lvl_lt_hold;
        logic       lvl_is_win;
        logic       hold;
        logic       win_user;
        logic       bal;
        logic       found;
        logic       last_ent;
        logic       sum_zero;
        logic       div_done;
        logic       out_free;
    } t_stat;

    // Tickets plus a signed change, clamped to max first and then to min.
    function automatic logic [7:0] clamp_tickets(input logic [7:0] t,
                                                 input logic signed [7:0] d,
                                                 input logic [7:0] mx,
                                                 input logic [7:0] mn);
        logic signed [9:0] s;
        s = $signed({2'b00, t}) + 10'(d);
        if (s > $signed({2'b00, mx})) s = $signed({2'b00, mx});
        if (s < $signed({2'b00, mn})) s = $signed({2'b00, mn});
        return s[7:0];
    endfunction

endpackage

[sv/lps_evt_if.sv]
interface lps_evt_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    logic [4:0]        slot;
    logic [4:0]        parent_slot;
    logic [3:0]        max_level;
    logic [15:0]       quantum;
    logic signed [7:0] ticket_delta;
    logic [31:0]       random;

    modport source(output valid, func, slot, parent_slot, max_level, quantum,
                   ticket_delta, random, input ready);
    modport sink(input valid, func, slot, parent_slot, max_level, quantum,
                 ticket_delta, random, output ready);
endinterface

[sv/lps_res_if.sv]
interface lps_res_if;
    logic        valid;
    logic        ready;
    logic        is_command;
    logic [4:0]  cmd_slot;
    logic [3:0]  cmd_level;
    logic [15:0] cmd_slice;
    logic [2:0]  status;
    logic        last;

    modport source(output valid, is_command, cmd_slot, cmd_level, cmd_slice,
                   status, last, input ready);
    modport sink(input valid, is_command, cmd_slot, cmd_level, cmd_slice,
                 status, last, output ready);
endinterface

[sv/lottery_process_scheduler_core.sv]
// Lottery process scheduler.
// Events arrive on i_evt (valid/ready); each beat is one event: start a
// system or user entry, stop, out of quantum, ticket change or balance.
// Results leave on o_res, one beat per schedule command, the final beat of
// an event marked by last and carrying the status. An event without a
// command gives a single status beat.
// One event is handled at a time. A stop or out of quantum runs a lottery: a
// summing walk and a search walk over the entry table around a bit-serial
// modulo. An out of quantum that hands out bonuses walks the table once more
// first. The entry table is a single-port memory, which sets the walk speed.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must do so only when no event is in flight, which the block does not enforce.
// Reset clears all entries to unused and loads the register defaults; it
// takes effect at once, no clearing pass.
// When o_res is stalled the block holds its work at the next result and
// resumes when the output register drains.
module lottery_process_scheduler_core #(
    parameter int NUM_ENTRIES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lps_evt_if.sink    i_evt,
    lps_res_if.source  o_res,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import lps_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int TW = $clog2(NUM_ENTRIES * 255 + 1);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;

    lps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_evt.valid),
        .o_ready (w_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    assign i_evt.ready = w_ready;

    lps_dp #(.N(NUM_ENTRIES), .IW(IW), .TW(TW)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_evt.func),
        .i_slot         (i_evt.slot),
        .i_parent_slot  (i_evt.parent_slot),
        .i_max_level    (i_evt.max_level),
        .i_quantum      (i_evt.quantum),
        .i_ticket_delta (i_evt.ticket_delta),
        .i_random       (i_evt.random),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_is_command   (o_res.is_command),
        .o_cmd_slot     (o_res.cmd_slot),
        .o_cmd_level    (o_res.cmd_level),
        .o_cmd_slice    (o_res.cmd_slice),
        .o_status       (o_res.status),
        .o_last         (o_res.last)
    );
endmodule

[sv/lps_mod.sv]
module lps_mod #(
    parameter int TW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [31:0]   i_dividend,
    input  logic [TW-1:0] i_divisor,
    output logic          o_done,
    output logic [TW-1:0] o_rem
);
    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [31:0]   r_q;
    logic [TW-1:0] r_rem;
    logic [TW:0]   w_trial;
    logic          w_ge;

    // One dividend bit per cycle, restoring form.
    assign w_trial = {r_rem, r_q[31]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], 1'b0};
            r_rem <= w_ge ? TW'(w_trial - {1'b0, i_divisor}) : w_trial[TW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

[sv/lps_ctrl.sv]
module lps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lps_pkg::t_stat i_stat,
    output lps_pkg::t_cmd  o_cmd
);
    import lps_pkg::*;

    t_state r_state, n_state;
    t_walk  r_walk, n_walk;
    t_cmd   w_cmd;
    logic   w_need_out;
    logic   w_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_walk  <= W_BAL;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
        end
    end

    assign w_stall = w_need_out && !i_stat.out_free;

    always_comb begin
        n_state = r_state;
        n_walk  = r_walk;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_DISP;
            S_DISP: begin
                if (!w_stall) begin
                    case (i_stat.func)
                        FN_START_SYS, FN_START_USR:
                            n_state = (!i_stat.slot_ok || i_stat.slot_used) ? S_IDLE : S_START;
                        FN_STOP:   n_state = i_stat.slot_used ? S_STOP : S_IDLE;
                        FN_OUT_Q:  n_state = i_stat.slot_used ? S_OQ_RD : S_IDLE;
                        FN_TICKET: n_state = i_stat.slot_used ? S_TK_RD : S_IDLE;
                        FN_BALANCE: begin
                            n_state = S_W_RD;
                            n_walk  = W_BAL;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_START: begin
                if (!w_stall) begin
                    if (i_stat.lev_bad) n_state = S_IDLE;
                    else if (i_stat.func == FN_START_SYS) n_state = S_FINOK;
                    else if (!i_stat.parent_ok) n_state = S_IDLE;
                    else n_state = S_PAR_RD;
                end
            end
            S_PAR_RD: if (!w_stall) n_state = S_USER;
            S_USER:   if (!w_stall) n_state = S_FINOK;
            S_FINOK:  if (!w_stall) n_state = S_IDLE;
            S_STOP: begin
                n_state = S_W_RD;
                n_walk  = W_SUM;
            end
            S_OQ_RD: n_state = S_OQ_ACT;
            S_OQ_ACT: begin
                if (i_stat.ent_user && !i_stat.lvl_is_win) begin
                    n_state = S_W_RD;
                    n_walk  = W_BONUS;
                end else begin
                    n_state = S_OQ_RD2;
                end
            end
            S_OQ_RD2: n_state = S_OQ_EMIT;
            S_OQ_EMIT: begin
                if (!w_stall) begin
                    n_state = S_W_RD;
                    n_walk  = W_SUM;
                end
            end
            S_TK_RD:  n_state = S_TK_ACT;
            S_TK_ACT: if (!w_stall) n_state = S_IDLE;
            S_W_RD:   n_state = S_W_ACT;
            S_W_ACT: begin
                if (!w_stall) begin
                    case (r_walk)
                        W_BAL:   n_state = i_stat.last_ent ? S_FINOK : S_W_RD;
                        W_BONUS: n_state = i_stat.last_ent ? S_OQ_RD2 : S_W_RD;
                        W_SUM:   n_state = i_stat.last_ent ? S_DIVCHK : S_W_RD;
                        W_FIND:  n_state = ((i_stat.hold && i_stat.found) || i_stat.last_ent)
                                           ? S_FINOK : S_W_RD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_DIVCHK: n_state = i_stat.sum_zero ? S_FINOK : S_DIV;
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_W_RD;
                    n_walk  = W_FIND;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_cmd      = '0;
        w_need_out = 1'b0;
        o_ready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                w_cmd.load = i_valid;
            end
            S_DISP: begin
                case (i_stat.func)
                    FN_START_SYS, FN_START_USR: begin
                        if (!i_stat.slot_ok) begin
                            w_need_out = 1'b1;
                            w_cmd.finish = 1'b1;
                            w_cmd.status = ST_UNUSED;
                        end else if (i_stat.slot_used) begin
                            w_need_out = 1'b1;
                            w_cmd.finish = 1'b1;
                            w_cmd.status = ST_BUSY;
                        end else begin
                            w_cmd.ptr_sel = PTR_SLOT;
                        end
                    end
                    FN_STOP, FN_OUT_Q, FN_TICKET: begin
                        if (!i_stat.slot_used) begin
                            w_need_out = 1'b1;
                            w_cmd.finish = 1'b1;
                            w_cmd.status = ST_UNUSED;
                        end else begin
                            w_cmd.ptr_sel = PTR_SLOT;
                        end
                    end
                    FN_BALANCE: w_cmd.ptr_sel = PTR_ZERO;
                    default: begin
                        w_need_out = 1'b1;
                        w_cmd.finish = 1'b1;
                        w_cmd.status = ST_OK;
                    end
                endcase
            end
            S_START: begin
                w_cmd.wr_maxlev  = 1'b1;
                w_cmd.wr_tickets = 1'b1;
                w_cmd.tk_sel     = TK_START;
                w_cmd.clr_user   = 1'b1;
                if (i_stat.lev_bad) begin
                    w_need_out = 1'b1;
                    w_cmd.finish = 1'b1;
                    w_cmd.status = ST_LEVEL;
                end else if (i_stat.func == FN_START_SYS) begin
                    w_need_out     = 1'b1;
                    w_cmd.wr_level = 1'b1;
                    w_cmd.lv_sel   = LV_MAXLEV;
                    w_cmd.wr_slice = 1'b1;
                    w_cmd.sl_sel   = SL_QUANTUM;
                    w_cmd.set_use  = 1'b1;
                    w_cmd.emit     = 1'b1;
                    w_cmd.em_sel   = EM_SYS;
                end else if (!i_stat.parent_ok) begin
                    w_need_out = 1'b1;
                    w_cmd.finish = 1'b1;
                    w_cmd.status = ST_PARENT;
                end else begin
                    w_cmd.ptr_sel = PTR_PARENT;
                end
            end
            // The parent's slice is only read here, so wait for room at the
            // output before leaving the parent address.
            S_PAR_RD: begin
                w_need_out    = 1'b1;
                w_cmd.ptr_sel = PTR_SLOT;
            end
            S_USER: begin
                w_need_out     = 1'b1;
                w_cmd.wr_level = 1'b1;
                w_cmd.lv_sel   = LV_HOLD;
                w_cmd.wr_slice = 1'b1;
                w_cmd.sl_sel   = SL_RD;
                w_cmd.set_use  = 1'b1;
                w_cmd.set_user = 1'b1;
                w_cmd.emit     = 1'b1;
                w_cmd.em_sel   = EM_USER;
            end
            S_FINOK: begin
                w_need_out   = 1'b1;
                w_cmd.finish = 1'b1;
                w_cmd.status = ST_OK;
            end
            S_STOP: begin
                w_cmd.clr_use  = 1'b1;
                w_cmd.clr_user = 1'b1;
                w_cmd.ptr_sel  = PTR_ZERO;
                w_cmd.sum_clr  = 1'b1;
            end
            S_OQ_ACT: begin
                if (!i_stat.ent_user && i_stat.lvl_lt_hold) begin
                    w_cmd.wr_level = 1'b1;
                    w_cmd.lv_sel   = LV_INC;
                end else if (i_stat.ent_user && i_stat.lvl_is_win) begin
                    w_cmd.wr_level   = 1'b1;
                    w_cmd.lv_sel     = LV_HOLD;
                    w_cmd.wr_tickets = 1'b1;
                    w_cmd.tk_sel     = TK_DEC;
                end else if (i_stat.ent_user) begin
                    w_cmd.ptr_sel = PTR_ZERO;
                end
            end
            S_OQ_EMIT: begin
                w_need_out    = 1'b1;
                w_cmd.emit    = 1'b1;
                w_cmd.em_sel  = EM_RD;
                w_cmd.ptr_sel = PTR_ZERO;
                w_cmd.sum_clr = 1'b1;
            end
            S_TK_ACT: begin
                w_need_out       = 1'b1;
                w_cmd.wr_tickets = 1'b1;
                w_cmd.tk_sel     = TK_DELTA;
                w_cmd.finish     = 1'b1;
                w_cmd.status     = ST_OK;
            end
            S_W_ACT: begin
                case (r_walk)
                    W_BAL: begin
                        if (i_stat.bal) begin
                            w_need_out     = 1'b1;
                            w_cmd.wr_level = 1'b1;
                            w_cmd.lv_sel   = LV_DEC;
                            w_cmd.emit     = 1'b1;
                            w_cmd.em_sel   = EM_BAL;
                        end
                        w_cmd.ptr_sel = i_stat.last_ent ? PTR_HOLD : PTR_INC;
                    end
                    W_BONUS: begin
                        if (i_stat.win_user) begin
                            w_cmd.wr_tickets = 1'b1;
                            w_cmd.tk_sel     = TK_INC;
                        end
                        w_cmd.ptr_sel = i_stat.last_ent ? PTR_SLOT : PTR_INC;
                    end
                    W_SUM: begin
                        w_cmd.sum_add = i_stat.hold;
                        w_cmd.ptr_sel = i_stat.last_ent ? PTR_HOLD : PTR_INC;
                    end
                    W_FIND: begin
                        if (i_stat.hold && i_stat.found) begin
                            w_need_out     = 1'b1;
                            w_cmd.wr_level = 1'b1;
                            w_cmd.lv_sel   = LV_WIN;
                            w_cmd.wr_slice = 1'b1;
                            w_cmd.sl_sel   = SL_UQ;
                            w_cmd.emit     = 1'b1;
                            w_cmd.em_sel   = EM_WIN;
                        end else begin
                            w_cmd.left_sub = i_stat.hold;
                            w_cmd.ptr_sel  = PTR_INC;
                        end
                    end
                    default: w_cmd = '0;
                endcase
            end
            S_DIVCHK: w_cmd.div_start = !i_stat.sum_zero;
            S_DIV: begin
                if (i_stat.div_done) begin
                    w_cmd.left_load = 1'b1;
                    w_cmd.ptr_sel   = PTR_ZERO;
                end
            end
            default: w_cmd = '0;
        endcase
        // A step that needs the result path gives no command while that path is full.
        o_cmd = w_stall ? t_cmd'('0) : w_cmd;
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free) else $error("emit while output full");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free) else $error("finish while output full");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_state == S_IDLE) else $error("finish did not end event");
`endif
endmodule

[sv/lps_dp.sv]
module lps_dp #(
    parameter int N  = 32,
    parameter int IW = 5,
    parameter int TW = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lps_pkg::t_cmd     i_cmd,
    output lps_pkg::t_stat    o_stat,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic [2:0]        i_func,
    input  logic [4:0]        i_slot,
    input  logic [4:0]        i_parent_slot,
    input  logic [3:0]        i_max_level,
    input  logic [15:0]       i_quantum,
    input  logic signed [7:0] i_ticket_delta,
    input  logic [31:0]       i_random,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_is_command,
    output logic [4:0]        o_cmd_slot,
    output logic [3:0]        o_cmd_level,
    output logic [15:0]       o_cmd_slice,
    output logic [2:0]        o_status,
    output logic              o_last
);
    import lps_pkg::*;

    logic [3:0]  r_hold;
    logic [4:0]  r_nq;
    logic [15:0] r_uq;
    logic [7:0]  r_st, r_mxt, r_mnt;

    logic [2:0]        r_func;
    logic [4:0]        r_slot, r_parent;
    logic [3:0]        r_maxlev;
    logic [15:0]       r_quantum;
    logic signed [7:0] r_delta;
    logic [31:0]       r_rnd;

    logic [N-1:0] r_use, r_user;
    logic [3:0]   m_level  [N];
    logic [3:0]   m_maxlev [N];
    logic [7:0]   m_tk     [N];
    logic [15:0]  m_slice  [N];
    logic [3:0]   r_rd_level, r_rd_maxlev;
    logic [7:0]   r_rd_tk;
    logic [15:0]  r_rd_slice;

    logic [IW-1:0] r_ptr, n_ptr;
    logic [TW-1:0] r_sum, r_left;
    logic [TW-1:0] w_rem;
    logic          w_div_done;

    logic        r_pend_v;
    logic [4:0]  r_pend_slot;
    logic [3:0]  r_pend_level;
    logic [15:0] r_pend_slice;
    logic [5:0]  r_cnt;

    logic        r_out_v, r_out_cmd, r_out_last;
    logic [4:0]  r_out_slot;
    logic [3:0]  r_out_level;
    logic [15:0] r_out_slice;
    logic [2:0]  r_out_status;

    logic [6:0]    w_slot7, w_par7;
    logic [IW-1:0] w_sidx, w_pidx;
    logic [3:0]    w_win;
    logic [3:0]    n_level;
    logic [7:0]    n_tk;
    logic [15:0]   n_slice;
    logic [4:0]    w_em_slot;
    logic [3:0]    w_em_level;
    logic [15:0]   w_em_slice;
    logic          w_cnt_ok, w_emit, w_push, w_out_free;

    assign w_slot7 = 7'(r_slot);
    assign w_par7  = 7'(r_parent);
    assign w_sidx  = w_slot7[IW-1:0];
    assign w_pidx  = w_par7[IW-1:0];
    assign w_win   = r_hold - 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 4'd15;
            r_nq   <= 5'd16;
            r_uq   <= 16'd200;
            r_st   <= 8'd20;
            r_mxt  <= 8'd100;
            r_mnt  <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD:  r_hold <= i_cfg_data[3:0];
                CFG_NQ:    r_nq   <= i_cfg_data[4:0];
                CFG_UQ:    r_uq   <= i_cfg_data;
                CFG_START: r_st   <= i_cfg_data[7:0];
                CFG_MAXTK: r_mxt  <= i_cfg_data[7:0];
                CFG_MINTK: r_mnt  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_slot    <= i_slot;
            r_parent  <= i_parent_slot;
            r_maxlev  <= i_max_level;
            r_quantum <= i_quantum;
            r_delta   <= i_ticket_delta;
            r_rnd     <= i_random;
        end
    end

    always_comb begin
        case (i_cmd.ptr_sel)
            PTR_SLOT:   n_ptr = w_sidx;
            PTR_PARENT: n_ptr = w_pidx;
            PTR_ZERO:   n_ptr = '0;
            PTR_INC:    n_ptr = r_ptr + IW'(1);
            default:    n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_use  <= '0;
            r_user <= '0;
        end else begin
            r_ptr <= n_ptr;
            if (i_cmd.set_use)  r_use[r_ptr]  <= 1'b1;
            if (i_cmd.clr_use)  r_use[r_ptr]  <= 1'b0;
            if (i_cmd.set_user) r_user[r_ptr] <= 1'b1;
            if (i_cmd.clr_user) r_user[r_ptr] <= 1'b0;
        end
    end

    always_comb begin
        case (i_cmd.lv_sel)
            LV_MAXLEV: n_level = r_maxlev;
            LV_HOLD:   n_level = r_hold;
            LV_WIN:    n_level = w_win;
            LV_INC:    n_level = r_rd_level + 4'd1;
            LV_DEC:    n_level = r_rd_level - 4'd1;
            default:   n_level = r_rd_level;
        endcase
        case (i_cmd.tk_sel)
            TK_START: n_tk = r_st;
            TK_DEC:   n_tk = clamp_tickets(r_rd_tk, -8'sd1, r_mxt, r_mnt);
            TK_INC:   n_tk = clamp_tickets(r_rd_tk, 8'sd1, r_mxt, r_mnt);
            TK_DELTA: n_tk = clamp_tickets(r_rd_tk, r_delta, r_mxt, r_mnt);
            default:  n_tk = r_rd_tk;
        endcase
        case (i_cmd.sl_sel)
            SL_QUANTUM: n_slice = r_quantum;
            SL_RD:      n_slice = r_rd_slice;
            SL_UQ:      n_slice = r_uq;
            default:    n_slice = r_rd_slice;
        endcase
    end

    // Entry table: one address, read data registered every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_level)   m_level[r_ptr]  <= n_level;
        if (i_cmd.wr_maxlev)  m_maxlev[r_ptr] <= r_maxlev;
        if (i_cmd.wr_tickets) m_tk[r_ptr]     <= n_tk;
        if (i_cmd.wr_slice)   m_slice[r_ptr]  <= n_slice;
        r_rd_level  <= m_level[r_ptr];
        r_rd_maxlev <= m_maxlev[r_ptr];
        r_rd_tk     <= m_tk[r_ptr];
        r_rd_slice  <= m_slice[r_ptr];
    end

    lps_mod #(.TW(TW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_sum),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr) r_sum <= '0;
        else if (i_cmd.sum_add) r_sum <= r_sum + TW'(r_rd_tk);
        if (i_cmd.left_load) r_left <= w_rem + TW'(1);
        else if (i_cmd.left_sub) r_left <= r_left - TW'(r_rd_tk);
    end

    always_comb begin
        case (i_cmd.em_sel)
            EM_SYS: begin
                w_em_slot = r_slot;  w_em_level = r_maxlev;  w_em_slice = r_quantum;
            end
            EM_USER: begin
                w_em_slot = r_slot;  w_em_level = r_hold;  w_em_slice = r_rd_slice;
            end
            EM_BAL: begin
                w_em_slot = 5'(r_ptr);  w_em_level = r_rd_level - 4'd1;
                w_em_slice = r_rd_slice;
            end
            EM_WIN: begin
                w_em_slot = 5'(r_ptr);  w_em_level = w_win;  w_em_slice = r_uq;
            end
            default: begin
                w_em_slot = 5'(r_ptr);  w_em_level = r_rd_level;  w_em_slice = r_rd_slice;
            end
        endcase
    end

    // A result waits in the pending stage until the next one, or the end of
    // the event, tells whether it is the last.
    assign w_cnt_ok   = r_cnt < 6'(MAX_RES);
    assign w_emit     = i_cmd.emit && w_cnt_ok;
    assign w_push     = (w_emit && r_pend_v) || i_cmd.finish;
    assign w_out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_cnt    <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pend_v <= 1'b0;
                r_cnt    <= '0;
            end else if (w_emit) begin
                r_pend_v <= 1'b1;
                r_cnt    <= r_cnt + 6'd1;
            end else if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
            end
            if (w_push) r_out_v <= 1'b1;
            else if (i_out_ready) r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pend_slot  <= w_em_slot;
            r_pend_level <= w_em_level;
            r_pend_slice <= w_em_slice;
        end
        if (w_push) begin
            r_out_cmd    <= r_pend_v;
            r_out_slot   <= r_pend_v ? r_pend_slot : 5'd0;
            r_out_level  <= r_pend_v ? r_pend_level : 4'd0;
            r_out_slice  <= r_pend_v ? r_pend_slice : 16'd0;
            r_out_status <= i_cmd.finish ? i_cmd.status : ST_OK;
            r_out_last   <= i_cmd.finish;
        end
    end

    always_comb begin
        o_stat.func        = r_func;
        o_stat.slot_ok     = w_slot7 < 7'(N);
        o_stat.slot_used   = (w_slot7 < 7'(N)) && r_use[w_sidx];
        o_stat.parent_ok   = (w_par7 < 7'(N)) && r_use[w_pidx];
        o_stat.lev_bad     = {1'b0, r_maxlev} >= r_nq;
        o_stat.ent_user    = r_user[r_ptr];
        o_stat.lvl_lt_hold = r_rd_level < r_hold;
        o_stat.lvl_is_win  = r_rd_level == w_win;
        o_stat.hold        = r_use[r_ptr] && r_user[r_ptr] && (r_rd_level == r_hold);
        o_stat.win_user    = r_use[r_ptr] && r_user[r_ptr] && (r_rd_level == w_win);
        o_stat.bal         = r_use[r_ptr] && !r_user[r_ptr] && (r_rd_level > r_rd_maxlev);
        o_stat.found       = r_left <= TW'(r_rd_tk);
        o_stat.last_ent    = r_ptr == IW'(N - 1);
        o_stat.sum_zero    = r_sum == '0;
        o_stat.div_done    = w_div_done;
        o_stat.out_free    = w_out_free;
    end

    assign o_out_valid  = r_out_v;
    assign o_is_command = r_out_cmd;
    assign o_cmd_slot   = r_out_slot;
    assign o_cmd_level  = r_out_level;
    assign o_cmd_slice  = r_out_slice;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;

`ifndef ASSERT_OFF
    a_load_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_pend_v) else $error("event accepted with result pending");
    a_pend_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_cnt != 6'd0 && r_cnt <= 6'(MAX_RES)))
        else $error("pending result count out of range");
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_out_free) else $error("result pushed into a full output");
`endif
endmodule
